// ===== rtl/core/scancode_to_ascii_decoder_defines.svh =====
// Assertion macros used by the decoder RTL.
`ifndef SCANCODE_TO_ASCII_DECODER_DEFINES_SVH
`define SCANCODE_TO_ASCII_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SCDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SCDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/scdec_pkg.sv =====
package scdec_pkg;

   localparam int unsigned KeyCount = 90;

   localparam logic [6:0] CODE_CTRL   = 7'd29;
   localparam logic [6:0] CODE_LSHIFT = 7'd42;
   localparam logic [6:0] CODE_RSHIFT = 7'd54;
   localparam logic [6:0] CODE_CAPS   = 7'd58;
   localparam logic [6:0] CHAR_CTRL_C = 7'h03;
   localparam logic [6:0] CHAR_LOWER_C = 7'h63;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;

   typedef logic [6:0] char_type;

   typedef struct packed {
      logic ctrl_held;
      logic shift_held;
      logic caps_on;
   } flags_type;

   typedef struct packed {
      logic      emit;
      char_type  ascii_char;
      flags_type flags;
   } decode_type;

   localparam char_type PLAIN_TAB [KeyCount] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam char_type SHIFT_TAB [KeyCount] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   function automatic char_type plain_lookup(input logic [6:0] code);
      plain_lookup = (32'(code) < KeyCount) ? PLAIN_TAB[code] : '0;
   endfunction

   function automatic char_type shift_lookup(input logic [6:0] code);
      shift_lookup = (32'(code) < KeyCount) ? SHIFT_TAB[code] : '0;
   endfunction

endpackage

// ===== rtl/core/scdec_decode.sv =====
module scdec_decode (
   input  logic [7:0]            scan_byte,
   input  scdec_pkg::flags_type  flags,
   output scdec_pkg::decode_type result
);
   import scdec_pkg::*;

   logic [6:0] code;
   char_type   plain_char;
   char_type   shift_char;
   logic       letter;
   logic       is_shift_key;

   assign code         = scan_byte[6:0];
   assign plain_char   = plain_lookup(code);
   assign shift_char   = shift_lookup(code);
   assign letter       = (shift_char >= CHAR_UPPER_A) && (shift_char <= CHAR_UPPER_Z);
   assign is_shift_key = (code == CODE_LSHIFT) || (code == CODE_RSHIFT);

   always_comb begin
      result.emit       = 1'b0;
      result.ascii_char = '0;
      result.flags      = flags;
      if (scan_byte[7]) begin
         priority if (code == CODE_CTRL) begin
            result.flags.ctrl_held = 1'b0;
         end else if (is_shift_key) begin
            result.flags.shift_held = 1'b0;
         end else begin
            result.flags.caps_on = flags.caps_on ^ (code == CODE_CAPS);
         end
      end else begin
         priority if (flags.ctrl_held) begin
            result.emit       = (plain_char == CHAR_LOWER_C);
            result.ascii_char = CHAR_CTRL_C;
         end else if (flags.shift_held || (flags.caps_on && letter)) begin
            result.emit       = (shift_char != '0);
            result.ascii_char = (flags.caps_on && flags.shift_held && letter) ?
                                plain_char : shift_char;
         end else if (plain_char != '0) begin
            result.emit       = 1'b1;
            result.ascii_char = plain_char;
         end else if (code == CODE_CTRL) begin
            result.flags.ctrl_held = 1'b1;
         end else begin
            result.flags.shift_held = flags.shift_held | is_shift_key;
         end
      end
   end

endmodule

// ===== rtl/core/scancode_to_ascii_decoder.sv =====
// Keyboard scancode (set 1) to ASCII decoder.
// The request channel (req_valid, req_stall, req_scan_byte) carries one
// scancode byte per transaction; bit 7 set marks a key release.
// The response channel (rsp_valid, rsp_stall, rsp_ascii_char) carries one
// ASCII character per transaction; control-C appears as 3.
// Releases and modifier presses update the control, shift and caps lock
// flags and produce no response; other presses produce zero or one.
// A byte is registered on acceptance, decoded through the two constant
// key tables in the following cycle, and its character is registered;
// a stalled receiver can hold the byte in the input register first.
// One request is accepted every cycle while the response side keeps up.
// When the receiver stalls, the response register holds its character
// and the input register holds a byte that would produce another one;
// req_stall rises only then. Bytes that produce nothing keep flowing.
// Synchronous reset clears all three flags and both valid bits.
module scancode_to_ascii_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_ascii_char
);
   import scdec_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   flags_type  flags_ff, flags_in;
   logic       out_valid_ff, out_valid_in;
   char_type   out_char_ff, out_char_in;

   decode_type dec;
   logic       out_free;
   logic       s1_advance;

   scdec_decode u_decode (
      .scan_byte (s1_byte_ff),
      .flags     (flags_ff),
      .result    (dec)
   );

   assign out_free   = ~out_valid_ff | ~rsp_stall;
   assign s1_advance = s1_valid_ff & (~dec.emit | out_free);
   assign req_stall  = s1_valid_ff & ~s1_advance;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      flags_in     = flags_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_char_in  = out_char_ff;
      if (s1_advance) begin
         flags_in    = dec.flags;
         s1_valid_in = 1'b0;
         if (dec.emit) begin
            out_valid_in = 1'b1;
            out_char_in  = dec.ascii_char;
         end
      end
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_scan_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
      s1_byte_ff  <= s1_byte_in;
      out_char_ff <= out_char_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;

`include "scancode_to_ascii_decoder_defines.svh"

   `SCDEC_ASSERT_NOW(a_release_silent, s1_valid_ff && s1_byte_ff[7], !dec.emit, "release emitted a character")
   `SCDEC_ASSERT_NOW(a_ctrl_gives_etx, s1_valid_ff && flags_ff.ctrl_held && dec.emit, dec.ascii_char == CHAR_CTRL_C, "control press gave a character other than 3")
   `SCDEC_ASSERT_NOW(a_stall_cause, req_stall, out_valid_ff && rsp_stall && dec.emit, "request stalled without a blocked response")
   `SCDEC_ASSERT_NEXT(a_emit_lands, s1_advance && dec.emit, out_valid_ff && out_char_ff != '0, "decoded character did not reach the response register")

endmodule

// ===== tb/scancode_to_ascii_decoder_test.sv =====
module scancode_to_ascii_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import scdec_pkg::*;

   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam logic [7:0] RELEASE_FLAG = 8'h80;

   localparam logic [6:0] UNSHIFTED_CHARS [90] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [6:0] SHIFTED_CHARS [90] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_scan_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_ascii_char;

   logic [7:0]  pending_bytes [$];
   logic [6:0]  expected_chars [$];
   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 47;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned chars_checked = 0;

   logic ctrl_down = 1'b0;
   logic shift_down = 1'b0;
   logic caps_active = 1'b0;

   scancode_to_ascii_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_scan_byte  (req_scan_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit decode_keystroke(input logic [7:0] scan, output logic [6:0] ch);
      logic [6:0] code;
      logic [6:0] plain;
      logic [6:0] shifted;
      logic       is_letter;
      code = scan[6:0];
      ch = '0;
      plain = (code < 7'd90) ? UNSHIFTED_CHARS[code] : '0;
      shifted = (code < 7'd90) ? SHIFTED_CHARS[code] : '0;
      is_letter = (shifted >= CHAR_UPPER_A) && (shifted <= CHAR_UPPER_Z);
      decode_keystroke = 1'b0;
      if (scan[7]) begin
         if (code == CODE_CTRL) begin
            ctrl_down = 1'b0;
         end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
            shift_down = 1'b0;
         end else if (code == CODE_CAPS) begin
            caps_active = ~caps_active;
         end
      end else if (ctrl_down) begin
         if (plain == CHAR_LOWER_C) begin
            ch = CHAR_CTRL_C;
            decode_keystroke = 1'b1;
         end
      end else if (shift_down || (caps_active && is_letter)) begin
         if (shifted != '0) begin
            ch = (caps_active && shift_down && is_letter) ? plain : shifted;
            decode_keystroke = 1'b1;
         end
      end else if (plain != '0) begin
         ch = plain;
         decode_keystroke = 1'b1;
      end else if (code == CODE_CTRL) begin
         ctrl_down = 1'b1;
      end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
         shift_down = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_scan_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      logic [6:0] want;
      logic [6:0] predicted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            bytes_sent++;
            if (decode_keystroke(req_scan_byte, predicted)) begin
               expected_chars.push_back(predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response transaction, ascii_char %h", rsp_ascii_char);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_ascii_char !== want) begin
                  $error("ascii_char: expected %h, actual %h", want, rsp_ascii_char);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic queue_random_typing(input int unsigned keys);
      int unsigned typed;
      int unsigned pick;
      logic [7:0]  code;
      typed = 0;
      while (typed < keys) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            code = 8'($urandom_range(89));
            pending_bytes.push_back(code);
            pending_bytes.push_back(code | RELEASE_FLAG);
            typed++;
         end else if (pick < 65) begin
            pending_bytes.push_back($urandom_range(1) ? 8'(CODE_LSHIFT) : 8'(CODE_RSHIFT));
         end else if (pick < 75) begin
            pending_bytes.push_back(($urandom_range(1) ? 8'(CODE_LSHIFT) : 8'(CODE_RSHIFT))
                                    | RELEASE_FLAG);
         end else if (pick < 78) begin
            pending_bytes.push_back(8'(CODE_CTRL));
         end else if (pick < 85) begin
            pending_bytes.push_back(8'(CODE_CTRL) | RELEASE_FLAG);
         end else if (pick < 90) begin
            pending_bytes.push_back(8'(CODE_CAPS));
            pending_bytes.push_back(8'(CODE_CAPS) | RELEASE_FLAG);
         end else begin
            pending_bytes.push_back(8'($urandom_range(255)));
            typed++;
         end
      end
   endtask

   initial begin : stimulus
      @(negedge clock);
      // Plain presses across the table edges and undefined codes.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h7F);
      pending_bytes.push_back(8'h5A);
      pending_bytes.push_back(8'h59);
      pending_bytes.push_back(8'h01);
      pending_bytes.push_back(8'h1E);
      pending_bytes.push_back(8'h4E);
      // Shift held; a control press under shift must be ignored.
      pending_bytes.push_back(8'h2A);
      pending_bytes.push_back(8'h1E);
      pending_bytes.push_back(8'h02);
      pending_bytes.push_back(8'h1D);
      pending_bytes.push_back(8'hAA);
      // Caps lock alone, then with shift, which gives lowercase letters.
      pending_bytes.push_back(8'hBA);
      pending_bytes.push_back(8'h1E);
      pending_bytes.push_back(8'h02);
      pending_bytes.push_back(8'h36);
      pending_bytes.push_back(8'h1E);
      pending_bytes.push_back(8'h02);
      pending_bytes.push_back(8'hB6);
      pending_bytes.push_back(8'hBA);
      // Control held, pressed twice, then released; odd releases last.
      pending_bytes.push_back(8'h1D);
      pending_bytes.push_back(8'h2E);
      pending_bytes.push_back(8'h1E);
      pending_bytes.push_back(8'h1D);
      pending_bytes.push_back(8'h9D);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h80);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      queue_random_typing(135);
      wait_for_drain();

      send_idle_pct = 47;
      recv_idle_pct = 6;
      queue_random_typing(135);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_typing(135);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d scancode bytes and checked %0d characters,", bytes_sent, chars_checked);
      $display("under sender-heavy, receiver-heavy and unthrottled flow control.");
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
